@@ rtl/odsa_pkg.sv @@
// Shared widths, constants and divider interface types for the dial step accumulator.
package odsa_pkg;

    localparam int ACC_W    = 14;
    localparam int DELTA_W  = 12;
    localparam int STEP_W   = 12;
    localparam int MAG_W    = 13;
    localparam int DIV_BITS = MAG_W;
    localparam int CNT_W    = $clog2(DIV_BITS);

    localparam logic [STEP_W-1:0]  STEP_RESET = 12'd1000;
    localparam logic [DELTA_W-1:0] OVF_POS    = 12'h7FF;
    localparam logic [DELTA_W-1:0] OVF_NEG    = 12'h801;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/optical_dial_step_accumulator.sv @@
// Top level: sample decode, accumulator sequencer and output register.
//
// Input stream (s_*): one word per sensor report. s_tuser bit 0 is the
// command (1 clears the accumulator), bit 1 the motion flag; s_tdata carries
// the X low byte, the Y low byte and the high-nibble byte.
// Output stream (m_*): exactly one word per input word. m_tuser is the
// step-valid flag, m_tdata the signed 14-bit step count (0 when no step).
// cfg_wr_en/cfg_wr_data load the dial step; write it only while idle.
// A value of 0 acts as 1.
// Flow: a clear or a report without motion goes from ST_IDLE through ST_OUT
// into the output register. A motion report runs the shared serial divider
// (one quotient bit per cycle, 13-bit quotient) once to reduce the
// accumulator when it has reached the step and once for the quotient when
// the sum reaches the step; the result then passes through ST_OUT into the
// output register before the next word is taken.
// s_tready is high only while the sequencer is idle.
// Reset clears the accumulator to 0, the dial step to 1000 and the output valid.
// If the receiver stalls, the finished word holds in the output register
// and the next result waits in its final state until that word is taken.
module optical_dial_step_accumulator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // x_low_byte, y_low_byte, high_nibbles
    input  logic [1:0]  s_tuser,   // command, motion_flag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // step_count, zero fill
    output logic        m_tuser,   // step_valid
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_ADD    = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_QUOT   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [odsa_pkg::STEP_W-1:0]     step_size_reg;
    logic signed [odsa_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [odsa_pkg::DELTA_W-1:0]    dx_reg, dx_next;
    logic [odsa_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            neg_reg, neg_next;
    logic                            res_valid_reg, res_valid_next;
    logic [odsa_pkg::ACC_W-1:0]      res_count_reg, res_count_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            m_tuser_reg, m_tuser_next;
    logic [odsa_pkg::ACC_W-1:0]      m_count_reg, m_count_next;

    logic                            accept;
    logic [odsa_pkg::DELTA_W-1:0]    x_raw, y_raw;
    logic                            ovf;
    logic [odsa_pkg::STEP_W-1:0]     step_eff;
    logic [odsa_pkg::ACC_W-1:0]      acc_abs;
    logic [odsa_pkg::MAG_W-1:0]      acc_mag;
    logic                            out_free;
    logic [odsa_pkg::ACC_W-1:0]      rem_ext, quo_ext;

    odsa_pkg::div_req_t              div_req;
    odsa_pkg::div_stat_t             div_stat;
    logic [odsa_pkg::MAG_W-1:0]      div_quo;
    logic [odsa_pkg::STEP_W-1:0]     div_rem;

    odsa_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign x_raw = {s_tdata[23:20], s_tdata[7:0]};
    assign y_raw = {s_tdata[19:16], s_tdata[15:8]};
    assign ovf   = (x_raw == odsa_pkg::OVF_POS) || (x_raw == odsa_pkg::OVF_NEG) ||
                   (y_raw == odsa_pkg::OVF_POS) || (y_raw == odsa_pkg::OVF_NEG);

    assign step_eff = (step_size_reg == '0) ? odsa_pkg::STEP_W'(1) : step_size_reg;
    assign acc_abs  = acc_reg[odsa_pkg::ACC_W-1] ? -acc_reg : acc_reg;
    assign acc_mag  = acc_abs[odsa_pkg::MAG_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign rem_ext  = {2'b00, div_rem};
    assign quo_ext  = {1'b0, div_quo};

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        dx_next         = dx_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        res_valid_next  = res_valid_reg;
        res_count_next  = res_count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_count_next    = m_count_reg;
        div_req.start    = 1'b0;
        div_req.dividend = acc_mag;
        div_req.divisor  = (state_reg == ST_IDLE) ? step_eff : step_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next = 1'b0;
                    res_count_next = '0;
                    step_next      = step_eff;
                    dx_next        = ovf ? '0 : x_raw;
                    neg_next       = acc_reg[odsa_pkg::ACC_W-1];
                    if (s_tuser[0])
                    begin
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end
                    else if (!s_tuser[1])
                    begin
                        state_next = ST_OUT;
                    end
                    else if ({1'b0, acc_mag} >= {2'b00, step_eff})
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_REDUCE;
                    end
                    else
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_REDUCE:
            begin
                // truncated remainder takes the sign of the dividend
                if (div_stat.done)
                begin
                    acc_next   = neg_reg ? -rem_ext : rem_ext;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                acc_next   = acc_reg + {{2{dx_reg[odsa_pkg::DELTA_W-1]}}, dx_reg};
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                neg_next = acc_reg[odsa_pkg::ACC_W-1];
                if ({1'b0, acc_mag} >= {2'b00, step_reg})
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_QUOT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_QUOT:
            begin
                if (div_stat.done)
                begin
                    res_valid_next = 1'b1;
                    res_count_next = neg_reg ? quo_ext : -quo_ext;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_valid_reg;
                    m_count_next  = res_count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_size_reg <= odsa_pkg::STEP_RESET;
            acc_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                step_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg        <= dx_next;
        step_reg      <= step_next;
        neg_reg       <= neg_next;
        res_valid_reg <= res_valid_next;
        res_count_reg <= res_count_next;
        m_tuser_reg   <= m_tuser_next;
        m_count_reg   <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {2'b00, m_count_reg};

`ifndef ASSERT_OFF
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ((state_reg == ST_REDUCE) || (state_reg == ST_QUOT)))
        else $error("divider finished outside a wait state");

    a_no_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
        else $error("nonzero count without a step");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((acc_reg >= -14'sd6142) && (acc_reg <= 14'sd6142)))
        else $error("accumulator out of range");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && out_free) |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result not loaded into output register");
`endif

endmodule

@@ rtl/odsa_divider.sv @@
// Restoring serial divider: one quotient bit per cycle for the accumulator magnitude.
module odsa_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  odsa_pkg::div_req_t             req,
    output odsa_pkg::div_stat_t            stat,
    output logic [odsa_pkg::MAG_W-1:0]     quotient,
    output logic [odsa_pkg::STEP_W-1:0]    remainder
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [odsa_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [odsa_pkg::STEP_W-1:0]   rem_reg, rem_next;
    logic [odsa_pkg::MAG_W-1:0]    quo_reg, quo_next;
    logic [odsa_pkg::STEP_W-1:0]   dvs_reg, dvs_next;

    logic [odsa_pkg::STEP_W:0]     shifted;
    logic [odsa_pkg::STEP_W+1:0]   diff;

    assign shifted = {rem_reg, quo_reg[odsa_pkg::MAG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            if (!diff[odsa_pkg::STEP_W+1])
            begin
                rem_next = diff[odsa_pkg::STEP_W-1:0];
                quo_next = {quo_reg[odsa_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[odsa_pkg::STEP_W-1:0];
                quo_next = {quo_reg[odsa_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == odsa_pkg::CNT_W'(odsa_pkg::DIV_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
